// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, quiet while reset is asserted
`define RPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define RPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/rpr_pkg.sv =====
// shared types, constants and saturation helper for the reprojection residual block
package rpr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_WORDS   = 16;
    localparam int INDEX_W     = $clog2(NUM_WORDS);
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 2;
    localparam int SAT_IN_W    = PROD_W + 4;
    localparam int DIV_STEPS   = PROD_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [INDEX_W-1:0] W_ROT0 = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] W_TX   = INDEX_W'(9);
    localparam logic [INDEX_W-1:0] W_TY   = INDEX_W'(10);
    localparam logic [INDEX_W-1:0] W_TZ   = INDEX_W'(11);
    localparam logic [INDEX_W-1:0] W_FX   = INDEX_W'(12);
    localparam logic [INDEX_W-1:0] W_FY   = INDEX_W'(13);
    localparam logic [INDEX_W-1:0] W_CX   = INDEX_W'(14);
    localparam logic [INDEX_W-1:0] W_CY   = INDEX_W'(15);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SAT_IN_W-1:0]    wide_t;

    // intrinsics and observation riding along with the point
    typedef struct packed {
        coord_t fx;
        coord_t fy;
        coord_t cx;
        coord_t cy;
        coord_t obs_u;
        coord_t obs_v;
    } proj_t;

    // what travels beside the divider lanes
    typedef struct packed {
        coord_t cx;
        coord_t cy;
        coord_t obs_u;
        coord_t obs_v;
        logic   neg_u;
        logic   neg_v;
        logic   sat;
        logic   clamped;
    } side_t;

    typedef struct packed {
        coord_t value;
        logic   flag;
    } sat_t;

    localparam wide_t COORD_MAX =
        {{(SAT_IN_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam wide_t COORD_MIN = ~COORD_MAX;

    function automatic sat_t sat_coord(input wide_t x);
        sat_t r;
        if (x > COORD_MAX) begin
            r.value = COORD_MAX[COORD_WIDTH-1:0];
            r.flag  = 1'b1;
        end
        else if (x < COORD_MIN) begin
            r.value = COORD_MIN[COORD_WIDTH-1:0];
            r.flag  = 1'b1;
        end
        else begin
            r.value = x[COORD_WIDTH-1:0];
            r.flag  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rpr_camera.sv =====
// camera word store written by load transactions
module rpr_camera (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [rpr_pkg::INDEX_W-1:0]      wr_index,
    input  rpr_pkg::coord_t                  wr_value,
    output rpr_pkg::coord_t                  words [rpr_pkg::NUM_WORDS]
);

    rpr_pkg::coord_t words_reg [rpr_pkg::NUM_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rpr_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            words_reg[wr_index] <= wr_value;
        end
    end

    assign words = words_reg;

endmodule

// ===== rtl/rpr_xform.sv =====
// rigid transform into camera space with depth clamp, three stages
`include "assert_macros.svh"
module rpr_xform (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rpr_pkg::coord_t   rot [9],
    input  rpr_pkg::coord_t   trans [3],
    input  rpr_pkg::coord_t   pt [3],
    input  rpr_pkg::proj_t    proj_in,
    output logic              out_valid,
    output rpr_pkg::coord_t   cam_x,
    output rpr_pkg::coord_t   cam_y,
    output rpr_pkg::coord_t   cam_z,
    output logic              sat_flag,
    output logic              clamped,
    output rpr_pkg::proj_t    proj_out
);

    // stage 1: nine products
    logic [2:0]                        valid_reg;
    rpr_pkg::prod_t                    prod_reg [9];
    rpr_pkg::prod_t                    prod_next [9];
    rpr_pkg::coord_t                   t1_reg [3];
    rpr_pkg::proj_t                    proj1_reg;
    // stage 2: row sums
    logic signed [rpr_pkg::SUM_W-1:0]  sum_reg [3];
    logic signed [rpr_pkg::SUM_W-1:0]  sum_next [3];
    rpr_pkg::coord_t                   t2_reg [3];
    rpr_pkg::proj_t                    proj2_reg;
    // stage 3: floor, translate, saturate, clamp
    rpr_pkg::coord_t                   coord_reg [3];
    rpr_pkg::coord_t                   coord_next [3];
    logic                              sat_reg;
    logic                              sat_next;
    logic                              clamped_reg;
    logic                              clamped_next;
    rpr_pkg::proj_t                    proj3_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3+c] = rpr_pkg::prod_t'(rot[r*3+c]) * rpr_pkg::prod_t'(pt[c]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = rpr_pkg::SUM_W'(prod_reg[r*3])
                        + rpr_pkg::SUM_W'(prod_reg[r*3+1])
                        + rpr_pkg::SUM_W'(prod_reg[r*3+2]);
        end
    end

    always_comb
    begin
        rpr_pkg::sat_t s;
        rpr_pkg::wide_t w;
        sat_next     = 1'b0;
        clamped_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            w = rpr_pkg::wide_t'(sum_reg[r] >>> rpr_pkg::FRAC_BITS)
              + rpr_pkg::wide_t'(t2_reg[r]);
            s = rpr_pkg::sat_coord(w);
            coord_next[r] = s.value;
            sat_next      = sat_next | s.flag;
        end
        // zero depth becomes one lsb
        if (coord_next[2] == '0)
        begin
            coord_next[2] = rpr_pkg::coord_t'(1);
            clamped_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            t1_reg      <= trans;
            proj1_reg   <= proj_in;
            sum_reg     <= sum_next;
            t2_reg      <= t1_reg;
            proj2_reg   <= proj1_reg;
            coord_reg   <= coord_next;
            sat_reg     <= sat_next;
            clamped_reg <= clamped_next;
            proj3_reg   <= proj2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign cam_x     = coord_reg[0];
    assign cam_y     = coord_reg[1];
    assign cam_z     = coord_reg[2];
    assign sat_flag  = sat_reg;
    assign clamped   = clamped_reg;
    assign proj_out  = proj3_reg;

    `RPR_ASSERT(a_clamp_gives_eps, clk, rst_n, valid_reg[2] && clamped_reg |-> coord_reg[2] == rpr_pkg::coord_t'(1), "clamped depth is not one lsb")
    `RPR_ASSERT(a_depth_nonzero, clk, rst_n, valid_reg[2] |-> coord_reg[2] != '0, "zero depth left the transform")

endmodule

// ===== rtl/rpr_div.sv =====
// focal products and pipelined restoring divider, two lanes sharing one divisor
`include "assert_macros.svh"
module rpr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  rpr_pkg::coord_t                 cam_x,
    input  rpr_pkg::coord_t                 cam_y,
    input  rpr_pkg::coord_t                 cam_z,
    input  logic                            sat_flag,
    input  logic                            clamped,
    input  rpr_pkg::proj_t                  proj_in,
    output logic                            out_valid,
    output logic [rpr_pkg::PROD_W-1:0]      quo_u,
    output logic [rpr_pkg::PROD_W-1:0]      quo_v,
    output rpr_pkg::side_t                  side_out
);

    localparam int N = rpr_pkg::DIV_STEPS;
    localparam int W = rpr_pkg::COORD_WIDTH;
    localparam int P = rpr_pkg::PROD_W;

    // front stage: focal products
    logic                 pv_reg;
    rpr_pkg::prod_t       pu_reg;
    rpr_pkg::prod_t       pvv_reg;
    rpr_pkg::coord_t      pz_reg;
    rpr_pkg::side_t       pside_reg;
    rpr_pkg::side_t       pside_next;

    // divider stages, index 0 holds magnitudes
    logic                 v_reg   [N+1];
    logic [P-1:0]         nu_reg  [N+1];
    logic [P-1:0]         nv_reg  [N+1];
    logic [W-1:0]         ru_reg  [N+1];
    logic [W-1:0]         rv_reg  [N+1];
    logic [W-1:0]         d_reg   [N+1];
    rpr_pkg::side_t       s_reg   [N+1];
    rpr_pkg::side_t       s0_next;

    always_comb
    begin
        pside_next.cx      = proj_in.cx;
        pside_next.cy      = proj_in.cy;
        pside_next.obs_u   = proj_in.obs_u;
        pside_next.obs_v   = proj_in.obs_v;
        pside_next.neg_u   = 1'b0;
        pside_next.neg_v   = 1'b0;
        pside_next.sat     = sat_flag;
        pside_next.clamped = clamped;
    end

    always_comb
    begin
        s0_next       = pside_reg;
        s0_next.neg_u = pu_reg[P-1] ^ pz_reg[W-1];
        s0_next.neg_v = pvv_reg[P-1] ^ pz_reg[W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            pv_reg   <= in_valid;
            v_reg[0] <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg    <= rpr_pkg::prod_t'(proj_in.fx) * rpr_pkg::prod_t'(cam_x);
            pvv_reg   <= rpr_pkg::prod_t'(proj_in.fy) * rpr_pkg::prod_t'(cam_y);
            pz_reg    <= cam_z;
            pside_reg <= pside_next;
            nu_reg[0] <= pu_reg[P-1] ? P'(-pu_reg) : P'(pu_reg);
            nv_reg[0] <= pvv_reg[P-1] ? P'(-pvv_reg) : P'(pvv_reg);
            ru_reg[0] <= '0;
            rv_reg[0] <= '0;
            d_reg[0]  <= pz_reg[W-1] ? W'(-pz_reg) : W'(pz_reg);
            s_reg[0]  <= s0_next;
        end
    end

    for (genvar s = 1; s <= N; s++)
    begin : g_step
        logic [W:0]   tu;
        logic [W:0]   tv;
        logic         qu;
        logic         qv;
        logic [W-1:0] ru_next;
        logic [W-1:0] rv_next;

        always_comb
        begin
            tu = {ru_reg[s-1], nu_reg[s-1][P-1]};
            tv = {rv_reg[s-1], nv_reg[s-1][P-1]};
            qu = tu >= {1'b0, d_reg[s-1]};
            qv = tv >= {1'b0, d_reg[s-1]};
            ru_next = qu ? W'(tu - {1'b0, d_reg[s-1]}) : W'(tu);
            rv_next = qv ? W'(tv - {1'b0, d_reg[s-1]}) : W'(tv);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ru_reg[s] <= ru_next;
                rv_reg[s] <= rv_next;
                nu_reg[s] <= {nu_reg[s-1][P-2:0], qu};
                nv_reg[s] <= {nv_reg[s-1][P-2:0], qv};
                d_reg[s]  <= d_reg[s-1];
                s_reg[s]  <= s_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quo_u     = nu_reg[N];
    assign quo_v     = nv_reg[N];
    assign side_out  = s_reg[N];

    `RPR_ASSERT(a_divisor_nonzero, clk, rst_n, v_reg[N] |-> d_reg[N] != '0, "divide by zero reached the end of the divider")
    `RPR_ASSERT(a_rem_below_divisor, clk, rst_n, v_reg[N] |-> ru_reg[N] < d_reg[N] && rv_reg[N] < d_reg[N], "divider remainder not below divisor")

endmodule

// ===== rtl/rpr_finish.sv =====
// signed quotient, principal point, residual and output register
module rpr_finish (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rpr_pkg::PROD_W-1:0]  quo_u,
    input  logic [rpr_pkg::PROD_W-1:0]  quo_v,
    input  rpr_pkg::side_t              side_in,
    output logic                        out_valid,
    output rpr_pkg::coord_t             residual_u,
    output rpr_pkg::coord_t             residual_v,
    output logic                        depth_clamped,
    output logic                        saturated
);

    logic [2:0]          valid_reg;
    rpr_pkg::wide_t      qu_reg;
    rpr_pkg::wide_t      qv_reg;
    rpr_pkg::side_t      s1_reg;
    rpr_pkg::coord_t     pu_reg;
    rpr_pkg::coord_t     pv_reg;
    rpr_pkg::side_t      s2_reg;
    rpr_pkg::side_t      s2_next;
    rpr_pkg::sat_t       pu_next;
    rpr_pkg::sat_t       pv_next;
    rpr_pkg::sat_t       ru_next;
    rpr_pkg::sat_t       rv_next;
    rpr_pkg::coord_t     ru_reg;
    rpr_pkg::coord_t     rv_reg;
    logic                clamped_reg;
    logic                sat_reg;

    always_comb
    begin
        pu_next = rpr_pkg::sat_coord(qu_reg + rpr_pkg::wide_t'(s1_reg.cx));
        pv_next = rpr_pkg::sat_coord(qv_reg + rpr_pkg::wide_t'(s1_reg.cy));
        s2_next     = s1_reg;
        s2_next.sat = s1_reg.sat | pu_next.flag | pv_next.flag;
        ru_next = rpr_pkg::sat_coord(rpr_pkg::wide_t'(pu_reg) - rpr_pkg::wide_t'(s2_reg.obs_u));
        rv_next = rpr_pkg::sat_coord(rpr_pkg::wide_t'(pv_reg) - rpr_pkg::wide_t'(s2_reg.obs_v));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qu_reg <= side_in.neg_u ? -rpr_pkg::wide_t'({1'b0, quo_u})
                                    : rpr_pkg::wide_t'({1'b0, quo_u});
            qv_reg <= side_in.neg_v ? -rpr_pkg::wide_t'({1'b0, quo_v})
                                    : rpr_pkg::wide_t'({1'b0, quo_v});
            s1_reg <= side_in;
            pu_reg <= pu_next.value;
            pv_reg <= pv_next.value;
            s2_reg <= s2_next;
            ru_reg <= ru_next.value;
            rv_reg <= rv_next.value;
            clamped_reg <= s2_reg.clamped;
            sat_reg     <= s2_reg.sat | ru_next.flag | rv_next.flag;
        end
    end

    assign out_valid     = valid_reg[2];
    assign residual_u    = ru_reg;
    assign residual_v    = rv_reg;
    assign depth_clamped = clamped_reg;
    assign saturated     = sat_reg;

endmodule

// ===== rtl/pinhole_reprojection_residual.sv =====
// top level: pinhole reprojection residual pipeline
// throughput: one transaction per cycle unless a result is held under out_stall; load transactions give no result
// the 64-step restoring divider (one quotient bit per stage) sets the depth
// the whole pipeline holds while a result waits under out_stall
// reset clears the camera words to zero and empties the pipeline
module pinhole_reprojection_residual (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [rpr_pkg::INDEX_W-1:0]      word_index,
    input  rpr_pkg::coord_t                  word_value,
    input  rpr_pkg::coord_t                  point_x,
    input  rpr_pkg::coord_t                  point_y,
    input  rpr_pkg::coord_t                  point_z,
    input  rpr_pkg::coord_t                  obs_u,
    input  rpr_pkg::coord_t                  obs_v,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output rpr_pkg::coord_t                  residual_u,
    output rpr_pkg::coord_t                  residual_v,
    output logic                             depth_clamped,
    output logic                             saturated
);

    logic                               en;
    logic                               in_fire;
    logic                               load_fire;
    logic                               eval_fire;
    rpr_pkg::coord_t                    words [rpr_pkg::NUM_WORDS];
    rpr_pkg::coord_t                    rot [9];
    rpr_pkg::coord_t                    trans [3];
    rpr_pkg::coord_t                    pt [3];
    rpr_pkg::proj_t                     proj_in;
    // transform to divider
    logic                               x_valid;
    rpr_pkg::coord_t                    cam_x;
    rpr_pkg::coord_t                    cam_y;
    rpr_pkg::coord_t                    cam_z;
    logic                               x_sat;
    logic                               x_clamped;
    rpr_pkg::proj_t                     x_proj;
    // divider to finish
    logic                               d_valid;
    logic [rpr_pkg::PROD_W-1:0]         quo_u;
    logic [rpr_pkg::PROD_W-1:0]         quo_v;
    rpr_pkg::side_t                     d_side;

    // every stage advances together unless a finished result is held back
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign in_fire   = in_valid && en;
    assign load_fire = in_fire && (command == rpr_pkg::CMD_LOAD);
    assign eval_fire = in_fire && (command == rpr_pkg::CMD_EVAL);

    rpr_camera u_camera (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_fire),
        .wr_index (word_index),
        .wr_value (word_value),
        .words    (words)
    );

    // camera words are sampled at acceptance so later loads never reach
    // an evaluate transaction already in flight
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            rot[i] = words[rpr_pkg::W_ROT0 + rpr_pkg::INDEX_W'(i)];
        end
        trans[0]      = words[rpr_pkg::W_TX];
        trans[1]      = words[rpr_pkg::W_TY];
        trans[2]      = words[rpr_pkg::W_TZ];
        pt[0]         = point_x;
        pt[1]         = point_y;
        pt[2]         = point_z;
        proj_in.fx    = words[rpr_pkg::W_FX];
        proj_in.fy    = words[rpr_pkg::W_FY];
        proj_in.cx    = words[rpr_pkg::W_CX];
        proj_in.cy    = words[rpr_pkg::W_CY];
        proj_in.obs_u = obs_u;
        proj_in.obs_v = obs_v;
    end

    // rotate, translate, saturate, clamp depth
    rpr_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (eval_fire),
        .rot       (rot),
        .trans     (trans),
        .pt        (pt),
        .proj_in   (proj_in),
        .out_valid (x_valid),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z),
        .sat_flag  (x_sat),
        .clamped   (x_clamped),
        .proj_out  (x_proj)
    );

    // focal products then truncating divide by depth
    rpr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x_valid),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z),
        .sat_flag  (x_sat),
        .clamped   (x_clamped),
        .proj_in   (x_proj),
        .out_valid (d_valid),
        .quo_u     (quo_u),
        .quo_v     (quo_v),
        .side_out  (d_side)
    );

    // sign, principal point, residual, output register
    rpr_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (d_valid),
        .quo_u         (quo_u),
        .quo_v         (quo_v),
        .side_in       (d_side),
        .out_valid     (out_valid),
        .residual_u    (residual_u),
        .residual_v    (residual_v),
        .depth_clamped (depth_clamped),
        .saturated     (saturated)
    );

endmodule
